/* rtl/spp_pkg.sv */
package spp_pkg;

  localparam int unsigned NUM_BINS = 1024;
  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam int unsigned MAG_W = 24;
  localparam int unsigned THR_W = 24;
  localparam int unsigned DEN_W = MAG_W + 1;
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned OUT_W = 25;

  // quotient bit counts of the two divisions
  localparam int unsigned QOFF_STEPS = FRAC_W - 1;
  localparam int unsigned QMAG_STEPS = MAG_W - 3;
  // vertex term divides by 8*den
  localparam int unsigned MAG_DIV_SHIFT = 3;
  localparam int unsigned REM_W = DEN_W + MAG_DIV_SHIFT + QMAG_STEPS - 1;
  localparam int unsigned STEP_W = $clog2(QMAG_STEPS);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // one detected peak, waiting for its refinement
  typedef struct packed {
    logic [BIN_W-1:0] pbin;
    logic [MAG_W-1:0] beta;
    logic [MAG_W-1:0] adiff;
    logic             neg;
    logic [DEN_W-1:0] den;
  } spp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spp_queue_status_t;

endpackage

/* rtl/spp_if.sv */
interface spp_bin_if;
  import spp_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             last_bin;
  modport source (output valid, output magnitude, output last_bin, input ready);
  modport sink (input valid, input magnitude, input last_bin, output ready);
endinterface

interface spp_cfg_if;
  import spp_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] peak_threshold;
  modport source (output valid, output peak_threshold, input ready);
  modport sink (input valid, input peak_threshold, output ready);
endinterface

interface spp_peak_if;
  import spp_pkg::*;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] peak_index;
  logic [OUT_W-1:0] refined_bin;
  logic [OUT_W-1:0] peak_magnitude;
  modport source (output valid, output peak_index, output refined_bin,
                  output peak_magnitude, input ready);
  modport sink (input valid, input peak_index, input refined_bin,
                input peak_magnitude, output ready);
endinterface

/* rtl/spectral_peak_picker_core.sv */
// spectral peak picker with parabolic refinement
//
// bin_i: magnitude bins of one spectrum in ascending order, last_bin marks the
//   final one; a transaction takes place when valid and ready are both high
// cfg_i: writes the peak threshold, always ready; write only while idle
// peak_o: one transaction per detected peak: integer bin, refined bin in
//   unsigned q.15 and the vertex magnitude truncated to an integer
//
// the front end judges bin c-1 when bin c arrives and takes one bin per cycle
// as long as the job queue (4 entries) has room; a peak becomes a queued job
// the back end refines one job at a time on a shared restoring divider, one
// quotient bit per cycle: 14 quotient bits for the offset, 21 for the vertex
// term; each job passes the offset division, the vertex division and the
// output state in that order before its result enters the output register
// a stalled receiver holds the output register; the back end then waits with
// its next result, the queue fills and bin_i.ready drops when it is full
// reset clears the bin history, the counter, the threshold and the queue
module spectral_peak_picker_core import spp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  spp_bin_if.sink    bin_i,
  spp_cfg_if.sink    cfg_i,
  spp_peak_if.source peak_o
);

  logic              push;
  logic              pop;
  spp_job_t          push_job;
  spp_job_t          head_job;
  spp_queue_status_t queue_status;

  // front end: history, bin counter, threshold and peak test
  spp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bin_valid_i  (bin_i.valid),
    .magnitude_i  (bin_i.magnitude),
    .last_bin_i   (bin_i.last_bin),
    .queue_full_i (queue_status.full),
    .bin_ready_o  (bin_i.ready),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_thr_i    (cfg_i.peak_threshold),
    .cfg_ready_o  (cfg_i.ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  // short job queue decouples bin intake from the divider
  spp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .status_o   (queue_status)
  );

  // back end: offset and vertex divisions plus output register
  spp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .queue_status_i   (queue_status),
    .head_job_i       (head_job),
    .pop_o            (pop),
    .peak_valid_o     (peak_o.valid),
    .peak_ready_i     (peak_o.ready),
    .peak_index_o     (peak_o.peak_index),
    .refined_bin_o    (peak_o.refined_bin),
    .peak_magnitude_o (peak_o.peak_magnitude)
  );

endmodule

/* rtl/spp_front.sv */
module spp_front import spp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             bin_valid_i,
  input  logic [MAG_W-1:0] magnitude_i,
  input  logic             last_bin_i,
  input  logic             queue_full_i,
  output logic             bin_ready_o,
  input  logic             cfg_valid_i,
  input  logic [THR_W-1:0] cfg_thr_i,
  output logic             cfg_ready_o,
  output logic             push_o,
  output spp_job_t         job_o
);

  logic [MAG_W-1:0] older_q, newer_q;
  logic [BIN_W-1:0] bin_cnt_q, bin_cnt_d;
  logic [THR_W-1:0] thr_q;
  logic             accept, is_peak, cnt_wrap;

  assign bin_ready_o = !queue_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept = bin_valid_i && bin_ready_o;

  // bin c-1 judged against c-2 and c
  assign is_peak = (bin_cnt_q >= BIN_W'(2)) && (newer_q > older_q) &&
                   (newer_q > magnitude_i) && (MAG_W'(newer_q) > thr_q);

  always_comb begin
    job_o.pbin = bin_cnt_q - BIN_W'(1);
    job_o.beta = newer_q;
    job_o.den = DEN_W'(newer_q - older_q) + DEN_W'(newer_q - magnitude_i);
    if (magnitude_i >= older_q) begin
      job_o.adiff = magnitude_i - older_q;
      job_o.neg = 1'b0;
    end else begin
      job_o.adiff = older_q - magnitude_i;
      job_o.neg = 1'b1;
    end
  end

  assign push_o = accept && is_peak;

  assign cnt_wrap = last_bin_i || (bin_cnt_q == BIN_W'(NUM_BINS - 1));
  assign bin_cnt_d = cnt_wrap ? '0 : bin_cnt_q + BIN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      bin_cnt_q <= '0;
      thr_q <= '0;
    end else begin
      if (accept) begin
        older_q <= newer_q;
        newer_q <= magnitude_i;
        bin_cnt_q <= bin_cnt_d;
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_thr_i;
      end
    end
  end

endmodule

/* rtl/spp_queue.sv */
module spp_queue import spp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spp_job_t          push_job_i,
  input  logic              pop_i,
  output spp_job_t          head_job_o,
  output spp_queue_status_t status_o
);

  spp_job_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign status_o.full = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop = pop_i && !status_o.empty;
  assign head_job_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10: count_q <= count_q + QCNT_W'(1);
        2'b01: count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/spp_back.sv */
module spp_back import spp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spp_queue_status_t queue_status_i,
  input  spp_job_t          head_job_i,
  output logic              pop_o,
  output logic              peak_valid_o,
  input  logic              peak_ready_i,
  output logic [BIN_W-1:0]  peak_index_o,
  output logic [OUT_W-1:0]  refined_bin_o,
  output logic [OUT_W-1:0]  peak_magnitude_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_OFF,
    S_DIV_MAG,
    S_OUT
  } state_e;

  state_e                   state_q;
  spp_job_t                 job_q;
  logic [REM_W-1:0]         rem_q, rem_d, dsh_q;
  logic [QMAG_STEPS-1:0]    quo_q, quo_d;
  logic [QOFF_STEPS-1:0]    qoff_q;
  logic [2*MAG_W-1:0]       sq_q;
  logic [STEP_W-1:0]        step_q;
  logic                     ge;
  logic [OUT_W-1:0]         base_bin, refined, vertex;
  logic                     out_free;
  logic                     out_load;
  logic                     out_valid_d;
  logic                     out_valid_q;
  logic [BIN_W-1:0]         out_bin_q;
  logic [OUT_W-1:0]         out_ref_q, out_mag_q;

  // one restoring step per cycle
  assign ge = (rem_q >= dsh_q);
  assign rem_d = ge ? rem_q - dsh_q : rem_q;
  assign quo_d = {quo_q[QMAG_STEPS-2:0], ge};

  assign base_bin = OUT_W'(job_q.pbin) << FRAC_W;
  assign refined = job_q.neg ? base_bin - OUT_W'(qoff_q) : base_bin + OUT_W'(qoff_q);
  assign vertex = OUT_W'(job_q.beta) + OUT_W'(quo_q);

  assign out_free = !out_valid_q || peak_ready_i;
  assign out_load = (state_q == S_OUT) && out_free;
  assign out_valid_d = out_load || (out_valid_q && !peak_ready_i);
  assign pop_o = (state_q == S_IDLE) && !queue_status_i.empty;

  always_ff @(posedge clk_i) begin
    sq_q <= job_q.adiff * job_q.adiff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      job_q <= '0;
      rem_q <= '0;
      dsh_q <= '0;
      quo_q <= '0;
      qoff_q <= '0;
      step_q <= '0;
      out_bin_q <= '0;
      out_ref_q <= '0;
      out_mag_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            job_q <= head_job_i;
            rem_q <= REM_W'(head_job_i.adiff) << QOFF_STEPS;
            dsh_q <= REM_W'(head_job_i.den) << (QOFF_STEPS - 1);
            quo_q <= '0;
            step_q <= STEP_W'(QOFF_STEPS - 1);
            state_q <= S_DIV_OFF;
          end
        end
        S_DIV_OFF: begin
          if (step_q == '0) begin
            qoff_q <= quo_d[QOFF_STEPS-1:0];
            rem_q <= REM_W'(sq_q);
            dsh_q <= REM_W'(job_q.den) << (MAG_DIV_SHIFT + QMAG_STEPS - 1);
            quo_q <= '0;
            step_q <= STEP_W'(QMAG_STEPS - 1);
            state_q <= S_DIV_MAG;
          end else begin
            rem_q <= rem_d;
            dsh_q <= dsh_q >> 1;
            quo_q <= quo_d;
            step_q <= step_q - STEP_W'(1);
          end
        end
        S_DIV_MAG: begin
          rem_q <= rem_d;
          dsh_q <= dsh_q >> 1;
          quo_q <= quo_d;
          if (step_q == '0) begin
            state_q <= S_OUT;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_bin_q <= job_q.pbin;
            out_ref_q <= refined;
            out_mag_q <= vertex;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign peak_valid_o = out_valid_q;
  assign peak_index_o = out_bin_q;
  assign refined_bin_o = out_ref_q;
  assign peak_magnitude_o = out_mag_q;

  // a peak always has a positive curvature term
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (job_q.den != '0))
    else $error("zero denominator on a queued peak");

  // the vertex never lies below the peak bin itself
  a_vertex_above_beta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (vertex >= OUT_W'(job_q.beta)))
    else $error("vertex magnitude below bin magnitude");

  // a new result only comes out of the output state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  // the offset division stays below the remainder bound
  a_offset_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_OFF && step_q == '0) |-> (rem_d < REM_W'(job_q.den)))
    else $error("offset quotient overflow");

endmodule
